// ----- design/pmau_pkg.sv -----
// Shared types and codes for the paged memory access unit.
`default_nettype none
package pmau_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIR   = 2'd1,
    ST_NO_TABLE = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_PAGING  = 1'b0,
    REG_DIRBASE = 1'b1
  } reg_idx_t;

  localparam int unsigned MAX_BYTES = 4;

endpackage
`default_nettype wire

// ----- design/pmau_req_if.sv -----
// Request channel: one access per transfer.
`default_nettype none
interface pmau_req_if
  import pmau_pkg::*;
();
  logic       valid;
  logic       ready;
  op_t        operation;
  logic [31:0] address;
  logic [2:0] length;
  logic [31:0] write_data;

  modport source (output valid, operation, address, length, write_data, input ready);
  modport sink (input valid, operation, address, length, write_data, output ready);
endinterface
`default_nettype wire

// ----- design/pmau_rsp_if.sv -----
// Response channel: read data and status per transfer.
`default_nettype none
interface pmau_rsp_if
  import pmau_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  status_t     status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

// ----- design/paged_memory_access_unit.sv -----
// Paged memory access unit: byte memory, two-level page walk, access sequencer.
`default_nettype none
// Carries out one read or write of up to 4 bytes per request against an internal
// byte memory of MEM_BYTES bytes, translating each byte through a two-level page
// walk when paging is on. The single memory port moves one byte per cycle and sets
// the rate; a length of zero moves no bytes. With paging, each page touched adds a
// walk of two four-byte entry reads. A request is taken only once the last is done.
// Consecutive bytes on the same page reuse the last walk. A fault ends the walk
// with nothing stored. The next request is taken while a response still waits.
// Memory contents are undefined until written.
module paged_memory_access_unit
  import pmau_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pmau_req_if.sink         req,
  pmau_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_XLATE  = 6'b000010,
    S_DIR    = 6'b000100,
    S_TBL    = 6'b001000,
    S_DATA   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic        paging_enabled;
  logic [19:0] directory_frame;

  op_t         op_r;
  logic [31:0] addr_r;
  logic [31:0] wdata_r;
  logic [2:0]  nbytes;
  logic [2:0]  bi;
  logic [2:0]  cnt;
  logic [1:0]  rd_slot;
  logic [31:0] entry;
  logic [19:0] tbl_frame;
  logic [19:0] frame;
  logic [19:0] tag;
  logic [AW-1:0] pa [MAX_BYTES];
  logic [31:0] rdata;
  status_t     status_r;

  logic        out_valid;
  logic [31:0] out_data;
  status_t     out_status;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q;
  logic [AW-1:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;

  logic [31:0] va;
  logic [31:0] dir_ea;
  logic [31:0] tbl_ea;
  logic [31:0] pde_tbl_ea;
  logic [31:0] entry_full;
  logic [31:0] hit_pa;
  logic [31:0] walk_pa;
  logic [32:0] flat_pa;
  logic        cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_PAGING:  prdata = {31'd0, paging_enabled};
      REG_DIRBASE: prdata = {12'd0, directory_frame};
      default:     prdata = 32'd0;
    endcase
  end

  // address arithmetic
  assign va         = addr_r + 32'(bi);
  assign dir_ea     = {directory_frame, va[31:22], 2'b00};
  assign tbl_ea     = {tbl_frame, va[21:12], 2'b00};
  assign entry_full = {mem_q, entry[31:8]};
  assign pde_tbl_ea = {entry_full[31:12], va[21:12], 2'b00};
  assign hit_pa     = {frame, va[11:0]};
  assign walk_pa    = {entry_full[31:12], va[11:0]};
  assign flat_pa    = {1'b0, addr_r} + 33'(bi);
  // read data arrives in the cycle after its address
  assign rd_slot    = cnt[1:0] - 2'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = wdata_r[8*cnt[1:0] +: 8];
    case (state)
      S_DIR:   mem_addr = {dir_ea[AW-1:2], cnt[1:0]};
      S_TBL:   mem_addr = {tbl_ea[AW-1:2], cnt[1:0]};
      S_DATA: begin
        mem_addr = pa[cnt[1:0]];
        mem_we   = (op_r == OP_WRITE) && (cnt < nbytes);
      end
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[mem_addr];
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_data;
  assign rsp.status     = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      paging_enabled  <= 1'b0;
      directory_frame <= 20'd0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_PAGING:  paging_enabled  <= pwdata[0];
          REG_DIRBASE: directory_frame <= pwdata[19:0];
          default: ;
        endcase
      end
      // S_FINISH loads the output register itself
      if (out_valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r     <= req.operation;
            addr_r   <= req.address;
            wdata_r  <= req.write_data;
            nbytes   <= (req.length > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : req.length;
            bi       <= 3'd0;
            rdata    <= 32'd0;
            status_r <= ST_OK;
            state    <= S_XLATE;
          end
        end

        S_XLATE: begin
          cnt <= 3'd0;
          if (bi == nbytes) begin
            state <= (nbytes == 3'd0) ? S_FINISH : S_DATA;
          end else if (!paging_enabled) begin
            if (flat_pa >= MEM_LIMIT) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else begin
              pa[bi[1:0]] <= flat_pa[AW-1:0];
              bi          <= bi + 3'd1;
            end
          end else if (bi != 3'd0 && va[31:12] == tag) begin
            // same page as the previous byte: reuse its frame
            if ({1'b0, hit_pa} >= MEM_LIMIT) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else begin
              pa[bi[1:0]] <= hit_pa[AW-1:0];
              bi          <= bi + 3'd1;
            end
          end else if (({1'b0, dir_ea} + 33'd4) > MEM_LIMIT) begin
            status_r <= ST_RANGE;
            state    <= S_FINISH;
          end else begin
            state <= S_DIR;
          end
        end

        S_DIR: begin
          // entry bytes arrive in the cycle after their address
          if (cnt != 3'd0) begin
            entry <= entry_full;
          end
          if (cnt == 3'd4) begin
            cnt <= 3'd0;
            if (!entry_full[0]) begin
              status_r <= ST_NO_DIR;
              state    <= S_FINISH;
            end else if (({1'b0, pde_tbl_ea} + 33'd4) > MEM_LIMIT) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else begin
              tbl_frame <= entry_full[31:12];
              state     <= S_TBL;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end

        S_TBL: begin
          if (cnt != 3'd0) begin
            entry <= entry_full;
          end
          if (cnt == 3'd4) begin
            cnt <= 3'd0;
            if (!entry_full[0]) begin
              status_r <= ST_NO_TABLE;
              state    <= S_FINISH;
            end else if ({1'b0, walk_pa} >= MEM_LIMIT) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else begin
              frame       <= entry_full[31:12];
              tag         <= va[31:12];
              pa[bi[1:0]] <= walk_pa[AW-1:0];
              bi          <= bi + 3'd1;
              state       <= S_XLATE;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end

        S_DATA: begin
          if (op_r == OP_READ && cnt != 3'd0) begin
            rdata[8*rd_slot +: 8] <= mem_q;
          end
          cnt <= cnt + 3'd1;
          if (cnt == nbytes) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_data   <= (status_r == ST_OK) ? rdata : 32'd0;
            out_status <= status_r;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
